>>> src/zops_pkg.sv
// Package: shared constants and types for the Z-order point sorter.
package zops_pkg;

    localparam int DIMS_DEF       = 3;
    localparam int MAX_POINTS_DEF = 64;
    localparam int DEPTH          = 64;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int COORD_W        = 32;
    localparam int KEY_W          = 64;
    localparam int SPAN_W         = 33;

    typedef enum logic [2:0] {
        S_LOAD,
        S_QREAD,
        S_QDIV,
        S_SORT,
        S_EMIT
    } t_state;

    // One sort pass step's compare result.
    typedef struct packed {
        logic swap;
        logic pass_done;
    } t_sort_stat;

endpackage

>>> src/zops_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module zops_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/zops_quant.sv
// Bit-serial quantizer: floor(off * 2^B / span), clamped, span 0 gives 0.
module zops_quant #(
    parameter int QBITS = 21
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [zops_pkg::SPAN_W-1:0]      i_off,
    input  logic [zops_pkg::SPAN_W-1:0]      i_span,
    output logic                             o_done,
    output logic [QBITS-1:0]                 o_cell
);
    localparam int STEP_W = $clog2(QBITS + 1);

    logic                          r_busy, n_busy;
    logic [STEP_W-1:0]             r_step, n_step;
    logic [zops_pkg::SPAN_W:0]     r_rem, n_rem;
    logic [QBITS:0]                r_q, n_q;
    logic [zops_pkg::SPAN_W-1:0]   r_span, n_span;
    logic                          r_done, n_done;
    logic [zops_pkg::SPAN_W:0]     w_sh;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_rem  = r_rem;
        n_q    = r_q;
        n_span = r_span;
        n_done = 1'b0;
        w_sh   = {r_rem[zops_pkg::SPAN_W-1:0], 1'b0};
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_span = i_span;
            if (i_off >= i_span) begin
                n_q   = {{QBITS{1'b0}}, 1'b1};
                n_rem = {1'b0, i_off - i_span};
            end else begin
                n_q   = '0;
                n_rem = {1'b0, i_off};
            end
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_span}) begin
                n_rem = w_sh - {1'b0, r_span};
                n_q   = {r_q[QBITS-1:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[QBITS-1:0], 1'b0};
            end
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(QBITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_span <= n_span;
    end

    // Quotient may reach 2^B only at the top of range; clamp. Zero span gives 0.
    assign o_done = r_done;
    assign o_cell = (r_span == '0) ? '0 :
                    (r_q[QBITS] ? {QBITS{1'b1}} : r_q[QBITS-1:0]);
endmodule

>>> src/zorder_point_sort.sv
// Top level: Z-order point sorter with coordinate and key memories.
//
// Usage: points arrive on the input channel (i_valid/o_ready), one request
// per cycle while loading. Each point's coordinates are written to per-axis
// memories and the bounding box is updated. A request with i_last_point set
// ends the set; unless the set is empty, the block then stops accepting and
// for each stored point reads its coordinates and runs one bit-serial divider
// per axis to build keys into the key memory. The index list is then ordered
// by an odd-even transposition sort over registers: the keys are loaded, then
// N passes run, each slot pair being read, then compared and swapped.
// Results leave on the output channel (o_valid/i_ready); a stall holds the
// result stable. After the final index the bounding box, count and drop flag
// clear and loading resumes.
// Points beyond MAX_POINTS are dropped and flagged in o_overflowed.
// Reset (i_rst_n low, synchronous) returns to loading an empty set; the
// memories are not cleared.
module zorder_point_sort #(
    parameter int DIMS       = zops_pkg::DIMS_DEF,
    parameter int MAX_POINTS = zops_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_coord_0,
    input  logic signed [31:0] i_coord_1,
    input  logic signed [31:0] i_coord_2,
    input  logic signed [31:0] i_coord_3,
    input  logic        i_last_point,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_point_index,
    output logic        o_final_index,
    output logic        o_overflowed
);
    localparam int QBITS = 64 / DIMS;
    localparam int IW    = zops_pkg::IDX_W;
    localparam int CW    = zops_pkg::CNT_W;
    localparam int KW    = zops_pkg::KEY_W;
    localparam int SW    = zops_pkg::SPAN_W;
    localparam int N     = zops_pkg::DEPTH;

    zops_pkg::t_state r_state, n_state;

    logic signed [31:0] w_cin [4];
    logic signed [31:0] r_min [4], n_min [4];
    logic signed [31:0] r_max [4], n_max [4];
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_drop, n_drop;
    logic [IW-1:0]      r_pt, n_pt;
    logic [KW-1:0]      r_key_acc;
    logic               w_acc;
    logic               w_store;
    logic [IW-1:0]      w_raddr;
    logic [31:0]        w_rd [4];
    logic [DIMS-1:0]    w_qdone;
    logic [QBITS-1:0]   w_cell [DIMS];
    logic               w_qstart;
    logic               r_qstart;
    logic               w_kwe;
    logic [KW-1:0]      w_key;

    // Sort registers: index and key per slot.
    logic [IW-1:0]      r_ord [N];
    logic [KW-1:0]      r_okey [N];
    logic [IW-1:0]      r_sp, n_sp;       // pair position
    logic [CW-1:0]      r_pass, n_pass;
    logic               r_kvalid;         // all keys loaded from key RAM into sort slots
    logic [CW-1:0]      r_eo, n_eo;
    logic               r_sph, n_sph;     // 0: read pair, 1: compare and swap
    logic               r_eph, n_eph;     // 0: read slot, 1: result presented
    logic [KW-1:0]      r_ka, r_kb;
    logic [IW-1:0]      r_ra, r_rb;
    logic [IW-1:0]      w_rda;
    zops_pkg::t_sort_stat w_stat;
    logic [IW:0]        w_pa;

    assign w_cin[0] = i_coord_0;
    assign w_cin[1] = i_coord_1;
    assign w_cin[2] = i_coord_2;
    assign w_cin[3] = i_coord_3;

    assign o_ready = (r_state == zops_pkg::S_LOAD);
    assign w_acc   = i_valid && o_ready;
    assign w_store = w_acc && (r_cnt < CW'(MAX_POINTS));

    assign w_raddr = r_pt;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_axis
            if (g < DIMS) begin : g_used
                zops_ram #(.WIDTH(32), .DEPTH(N)) u_axis (
                    .i_clk  (i_clk),
                    .i_we   (w_store),
                    .i_waddr(r_cnt[IW-1:0]),
                    .i_wdata(w_cin[g]),
                    .i_raddr(w_raddr),
                    .o_rdata(w_rd[g])
                );
            end else begin : g_unused
                assign w_rd[g] = '0;
            end
        end
        for (g = 0; g < DIMS; g++) begin : g_quant
            logic [SW-1:0] w_off, w_span;
            assign w_off  = SW'({w_rd[g][31], w_rd[g]} - {r_min[g][31], r_min[g]});
            assign w_span = SW'({r_max[g][31], r_max[g]} - {r_min[g][31], r_min[g]});
            zops_quant #(.QBITS(QBITS)) u_quant (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_start(w_qstart),
                .i_off  (w_off),
                .i_span (w_span),
                .o_done (w_qdone[g]),
                .o_cell (w_cell[g])
            );
        end
    endgenerate

    always_comb begin
        w_key = '0;
        for (int d = 0; d < DIMS; d++) begin
            for (int b = 0; b < QBITS; b++) begin
                w_key[b * DIMS + d] = w_cell[d][b];
            end
        end
    end

    assign w_qstart = r_qstart;
    assign w_kwe    = (r_state == zops_pkg::S_QDIV) && w_qdone[0];

    zops_ram #(.WIDTH(KW), .DEPTH(N)) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_kwe),
        .i_waddr(r_pt),
        .i_wdata(w_key),
        .i_raddr(r_pt),
        .o_rdata(r_key_acc)
    );

    // Odd-even transposition: compare slot pair (w_pa, w_pa+1).
    assign w_pa  = {r_sp, 1'b0} + (IW+1)'(r_pass[0]);
    assign w_rda = (r_state == zops_pkg::S_EMIT) ? r_eo[IW-1:0] : w_pa[IW-1:0];
    always_comb begin
        w_stat.swap = 1'b0;
        if (w_pa + 1'b1 < r_cnt) begin
            w_stat.swap = r_ka > r_kb;
        end
        w_stat.pass_done = ((w_pa + 2'd3) >= (IW+1)'(r_cnt)) ||
                           (r_sp == {IW{1'b1}});
    end

    always_comb begin
        n_state = r_state;
        n_min   = r_min;
        n_max   = r_max;
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        n_pt    = r_pt;
        n_sp    = r_sp;
        n_pass  = r_pass;
        n_eo    = r_eo;
        n_sph   = 1'b0;
        n_eph   = 1'b0;
        unique case (r_state)
            zops_pkg::S_LOAD: begin
                if (w_acc) begin
                    if (w_store) begin
                        for (int d = 0; d < DIMS; d++) begin
                            if (w_cin[d] < r_min[d]) n_min[d] = w_cin[d];
                            if (w_cin[d] > r_max[d]) n_max[d] = w_cin[d];
                        end
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_point) begin
                        n_pt = '0;
                        if ((w_store ? r_cnt + 1'b1 : r_cnt) == '0) begin
                            n_state = zops_pkg::S_LOAD;
                        end else begin
                            n_state = zops_pkg::S_QREAD;
                        end
                    end
                end
            end
            zops_pkg::S_QREAD: begin
                // coordinate read of r_pt issued here; divider starts next cycle
                n_state = zops_pkg::S_QDIV;
            end
            zops_pkg::S_QDIV: begin
                if (w_qdone[0]) begin
                    if (CW'(r_pt) + 1'b1 == r_cnt) begin
                        n_state = zops_pkg::S_SORT;
                        n_sp    = '0;
                        n_pass  = '0;
                        n_pt    = '0;
                    end else begin
                        n_pt    = r_pt + 1'b1;
                        n_state = zops_pkg::S_QREAD;
                    end
                end
            end
            zops_pkg::S_SORT: begin
                // keys load from RAM into the sort slots first, then passes
                if (!r_kvalid) begin
                    if (CW'(r_pt) + 1'b1 == r_cnt || r_pt == {IW{1'b1}}) begin
                        n_pt = r_pt;
                    end else begin
                        n_pt = r_pt + 1'b1;
                    end
                end else if (!r_sph) begin
                    n_sph = 1'b1;
                end else if (w_stat.pass_done) begin
                    n_sp   = '0;
                    n_pass = r_pass + 1'b1;
                    if (r_pass + 1'b1 == r_cnt) begin
                        n_state = zops_pkg::S_EMIT;
                        n_eo    = '0;
                    end
                end else begin
                    n_sp = r_sp + 1'b1;
                end
            end
            zops_pkg::S_EMIT: begin
                if (!r_eph) begin
                    n_eph = 1'b1;
                end else if (i_ready) begin
                    n_eo = r_eo + 1'b1;
                    if (r_eo + 1'b1 == r_cnt) begin
                        n_state = zops_pkg::S_LOAD;
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        for (int d = 0; d < 4; d++) begin
                            n_min[d] = 32'sh7FFF_FFFF;
                            n_max[d] = 32'sh8000_0000;
                        end
                    end
                end else begin
                    n_eph = 1'b1;
                end
            end
            default: n_state = zops_pkg::S_LOAD;
        endcase
        if (r_state == zops_pkg::S_LOAD && w_acc && i_last_point &&
            (w_store ? r_cnt + 1'b1 : r_cnt) == '0) begin
            n_drop = 1'b0;
        end
    end

    // Key load into sort slots: key RAM read of r_pt lands in the following cycle.
    logic [IW-1:0] r_ld_pt;
    logic          r_ld_v;
    logic          r_ld_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= zops_pkg::S_LOAD;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_kvalid <= 1'b0;
            r_ld_v   <= 1'b0;
            r_ld_last <= 1'b0;
            r_qstart <= 1'b0;
            r_sph    <= 1'b0;
            r_eph    <= 1'b0;
            for (int d = 0; d < 4; d++) begin
                r_min[d] <= 32'sh7FFF_FFFF;
                r_max[d] <= 32'sh8000_0000;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_min   <= n_min;
            r_max   <= n_max;
            r_qstart <= (r_state == zops_pkg::S_QREAD);
            r_sph   <= n_sph;
            r_eph   <= n_eph;
            if (r_state == zops_pkg::S_SORT && !r_kvalid) begin
                r_ld_v    <= 1'b1;
                r_ld_last <= (CW'(r_pt) + 1'b1 == r_cnt) || r_pt == {IW{1'b1}};
                if (r_ld_v && r_ld_last) begin
                    r_kvalid <= 1'b1;
                end
            end else begin
                r_ld_v    <= 1'b0;
                r_ld_last <= 1'b0;
                if (r_state != zops_pkg::S_SORT) begin
                    r_kvalid <= 1'b0;
                end
            end
        end
        r_pt    <= n_pt;
        r_sp    <= n_sp;
        r_pass  <= n_pass;
        r_eo    <= n_eo;
        r_ld_pt <= r_pt;
        r_ra    <= r_ord[w_rda];
        r_rb    <= r_ord[w_pa[IW-1:0] + 1'b1];
        r_ka    <= r_okey[w_pa[IW-1:0]];
        r_kb    <= r_okey[w_pa[IW-1:0] + 1'b1];
        if (r_state == zops_pkg::S_SORT && !r_kvalid && r_ld_v) begin
            r_ord[r_ld_pt]  <= r_ld_pt;
            r_okey[r_ld_pt] <= r_key_acc;
        end else if (r_state == zops_pkg::S_SORT && r_kvalid && r_sph && w_stat.swap) begin
            r_ord[w_pa[IW-1:0]]         <= r_rb;
            r_ord[w_pa[IW-1:0] + 1'b1]  <= r_ra;
            r_okey[w_pa[IW-1:0]]        <= r_kb;
            r_okey[w_pa[IW-1:0] + 1'b1] <= r_ka;
        end
    end

    assign o_valid       = (r_state == zops_pkg::S_EMIT) && r_eph;
    assign o_point_index = r_ra;
    assign o_final_index = (r_eo + 1'b1 == r_cnt);
    assign o_overflowed  = r_drop;
endmodule
